FILE: hw/rtl/sync_length_crc_frame_deframer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sync / length / CRC frame deframer
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_CRC_FRAME_DEFRAMER_ASSERT_SVH
`define SYNC_LENGTH_CRC_FRAME_DEFRAMER_ASSERT_SVH

// same-cycle implication
`define SLDF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// next-cycle implication
`define SLDF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

FILE: hw/rtl/sldf_pkg.sv
// ----------------------------------------------------------------------------
// sldf_pkg
// Types and constants shared by the frame deframer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sldf_pkg;

  localparam logic [15:0] CRC_INIT = 16'h1D0F;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [15:0] TYPE_S1 = 16'h7331;
  localparam logic [15:0] TYPE_G1 = 16'h6731;
  localparam logic [15:0] TYPE_I1 = 16'h6931;

  localparam logic [7:0] SYNC_BYTE_RST       = 8'h55;
  localparam logic [8:0] MAX_FRAME_INDEX_RST = 9'd256;

  typedef enum logic [1:0] {
    CFG_SYNC_BYTE       = 2'd0,
    CFG_MAX_FRAME_INDEX = 2'd1
  } cfg_index_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_END     = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    CLASS_S1      = 2'd0,
    CLASS_G1      = 2'd1,
    CLASS_I1      = 2'd2,
    CLASS_UNKNOWN = 2'd3
  } type_class_t;

  typedef enum logic [1:0] {
    STATUS_CRC_GOOD = 2'd0,
    STATUS_CRC_BAD  = 2'd1,
    STATUS_OVERSIZE = 2'd2
  } frame_status_t;

  function automatic type_class_t class_of(input logic [15:0] t);
    type_class_t c;
    priority if (t == TYPE_S1) c = CLASS_S1;
    else if (t == TYPE_G1)     c = CLASS_G1;
    else if (t == TYPE_I1)     c = CLASS_I1;
    else                       c = CLASS_UNKNOWN;
    return c;
  endfunction

endpackage

FILE: hw/rtl/sldf_crc16_byte.sv
// ----------------------------------------------------------------------------
// sldf_crc16_byte
// One-byte update of a CRC-16 with polynomial 0x1021, MSB first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sldf_crc16_byte (
  input  logic [15:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [15:0] crc_o
);
  import sldf_pkg::*;

  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {byte_i, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_o = c;
  end

endmodule

FILE: hw/rtl/sync_length_crc_frame_deframer.sv
// ----------------------------------------------------------------------------
// sync_length_crc_frame_deframer
// Hunts for a double sync byte, then parses type, length, payload and a
// big-endian CRC-16, emitting payload bytes and one end report per frame.
// ----------------------------------------------------------------------------
// One received byte is taken per clock unless stalled. Each accepted item is
// parsed in the same cycle and its result, if any, appears in the output
// register on the next cycle; rate is one item per cycle when unstalled. The
// single output register sets the stall path: in_stall is high only while a
// result is held and out_stall is high. Configuration writes are always ready.
`timescale 1ns / 1ps

module sync_length_crc_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_payload_byte,
  output logic [15:0] out_packet_type,
  output logic [1:0]  out_type_class,
  output logic [1:0]  out_frame_status,
  output logic [7:0]  out_payload_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import sldf_pkg::*;

  logic [7:0]  sync_byte_r;
  logic [8:0]  max_frame_index_r;

  logic        in_frame_r,      in_frame_nxt;
  logic        prev_sync_r,     prev_sync_nxt;
  logic [8:0]  frame_index_r,   frame_index_nxt;
  logic [7:0]  length_r,        length_nxt;
  logic [15:0] crc_r,           crc_nxt;
  logic [15:0] type_r,          type_nxt;
  logic [7:0]  crc_high_r,      crc_high_nxt;

  logic          out_valid_r;
  kind_t         out_kind_r,   kind_nxt;
  logic [7:0]    out_pb_r,     pb_nxt;
  logic [15:0]   out_type_r;
  type_class_t   out_class_r;
  frame_status_t out_status_r, status_nxt;
  logic [7:0]    out_len_r;

  logic        in_accept;
  logic        emit;
  logic [8:0]  idx_inc;
  logic [9:0]  payload_last;
  logic [15:0] crc_upd;
  logic        is_sync;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_byte_r       <= SYNC_BYTE_RST;
      max_frame_index_r <= MAX_FRAME_INDEX_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SYNC_BYTE:       sync_byte_r       <= cfg_wdata[7:0];
        CFG_MAX_FRAME_INDEX: max_frame_index_r <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  sldf_crc16_byte u_crc (
    .crc_i  (crc_r),
    .byte_i (in_rx_byte),
    .crc_o  (crc_upd)
  );

  assign is_sync      = (in_rx_byte == sync_byte_r);
  assign idx_inc      = frame_index_r + 9'd1;
  assign payload_last = {2'b00, length_r} + 10'd4;

  always_comb begin
    in_frame_nxt    = in_frame_r;
    prev_sync_nxt   = prev_sync_r;
    frame_index_nxt = frame_index_r;
    length_nxt      = length_r;
    crc_nxt         = crc_r;
    type_nxt        = type_r;
    crc_high_nxt    = crc_high_r;
    emit            = 1'b0;
    kind_nxt        = KIND_END;
    pb_nxt          = 8'h00;
    status_nxt      = STATUS_CRC_GOOD;
    if (!in_frame_r) begin
      if (prev_sync_r && is_sync) begin
        in_frame_nxt    = 1'b1;
        prev_sync_nxt   = 1'b0;
        frame_index_nxt = 9'd1;
        length_nxt      = 8'h00;
        crc_nxt         = CRC_INIT;
        type_nxt        = 16'h0000;
        crc_high_nxt    = 8'h00;
      end else begin
        prev_sync_nxt = is_sync;
      end
    end else begin
      frame_index_nxt = idx_inc;
      priority if (idx_inc > max_frame_index_r) begin
        in_frame_nxt  = 1'b0;
        prev_sync_nxt = 1'b0;
        emit          = 1'b1;
        status_nxt    = STATUS_OVERSIZE;
      end else if (idx_inc == 9'd2 || idx_inc == 9'd3) begin
        type_nxt = {type_r[7:0], in_rx_byte};
        crc_nxt  = crc_upd;
      end else if (idx_inc == 9'd4) begin
        length_nxt = in_rx_byte;
        crc_nxt    = crc_upd;
      end else if ({1'b0, idx_inc} <= payload_last) begin
        crc_nxt  = crc_upd;
        emit     = 1'b1;
        kind_nxt = KIND_PAYLOAD;
        pb_nxt   = in_rx_byte;
      end else if ({1'b0, idx_inc} == payload_last + 10'd1) begin
        crc_high_nxt = in_rx_byte;
      end else begin
        in_frame_nxt  = 1'b0;
        prev_sync_nxt = 1'b0;
        emit          = 1'b1;
        status_nxt    = ({crc_high_r, in_rx_byte} == crc_r) ? STATUS_CRC_GOOD
                                                            : STATUS_CRC_BAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r    <= 1'b0;
      prev_sync_r   <= 1'b0;
      frame_index_r <= 9'd0;
      length_r      <= 8'h00;
      crc_r         <= CRC_INIT;
      type_r        <= 16'h0000;
      crc_high_r    <= 8'h00;
    end else if (in_accept) begin
      in_frame_r    <= in_frame_nxt;
      prev_sync_r   <= prev_sync_nxt;
      frame_index_r <= frame_index_nxt;
      length_r      <= length_nxt;
      crc_r         <= crc_nxt;
      type_r        <= type_nxt;
      crc_high_r    <= crc_high_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= in_accept && emit;
    end
  end

  // payload and length seen by the report are the values after this byte
  always_ff @(posedge clk) begin
    if (in_accept && emit) begin
      out_kind_r   <= kind_nxt;
      out_pb_r     <= pb_nxt;
      out_type_r   <= type_nxt;
      out_class_r  <= class_of(type_nxt);
      out_status_r <= status_nxt;
      out_len_r    <= length_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_payload_byte   = out_pb_r;
  assign out_packet_type    = out_type_r;
  assign out_type_class     = out_class_r;
  assign out_frame_status   = out_status_r;
  assign out_payload_length = out_len_r;

  `include "sync_length_crc_frame_deframer_assert.svh"

  `SLDF_ASSERT_NOW(a_payload_status, clk, rst_n, out_valid_r && out_kind_r == KIND_PAYLOAD, out_status_r == STATUS_CRC_GOOD)
  `SLDF_ASSERT_NOW(a_end_no_byte, clk, rst_n, out_valid_r && out_kind_r == KIND_END, out_pb_r == 8'h00)
  `SLDF_ASSERT_NOW(a_frame_index, clk, rst_n, in_frame_r, frame_index_r != 9'd0)
  `SLDF_ASSERT_NEXT(a_hunt_silent, clk, rst_n, in_accept && !in_frame_r, !out_valid_r)

endmodule

FILE: tb/sync_length_crc_frame_deframer_checker.sv
// ----------------------------------------------------------------------------
// Frame deframer checker
// Watches the rx byte, result and register write channels, keeps its own
// copy of the deframer state and compares every result item in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sync_length_crc_frame_deframer_checker
  import sldf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_kind,
  input  logic [7:0]  out_payload_byte,
  input  logic [15:0] out_packet_type,
  input  logic [1:0]  out_type_class,
  input  logic [1:0]  out_frame_status,
  input  logic [7:0]  out_payload_length,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          n_fail,
  output int          n_pending,
  output int          n_checked,
  output int          n_good,
  output int          n_bad,
  output int          n_drop
);

  typedef struct {
    kind_t         kind;
    logic [7:0]    payload_byte;
    logic [15:0]   packet_type;
    type_class_t   type_class;
    frame_status_t frame_status;
    logic [7:0]    payload_length;
  } frame_result_t;

  frame_result_t frame_results_q[$];

  logic [7:0]  sync_val;
  logic [8:0]  index_limit;
  bit          framing;
  bit          sync_armed;
  logic [8:0]  byte_pos;
  logic [7:0]  len_byte;
  logic [15:0] crc_run;
  logic [15:0] ptype;
  logic [7:0]  crc_hi;

  int            fails;
  int            checked;
  int            good_cnt;
  int            bad_cnt;
  int            drop_cnt;
  int            diffs;
  frame_result_t oldest;

  function automatic logic [15:0] crc16_next(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    int          k;
    c = crc ^ {b, 8'h00};
    for (k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic type_class_t class_for(logic [15:0] t);
    case (t)
      TYPE_S1: return CLASS_S1;
      TYPE_G1: return CLASS_G1;
      TYPE_I1: return CLASS_I1;
      default: return CLASS_UNKNOWN;
    endcase
  endfunction

  function automatic frame_result_t make_result(kind_t k, logic [7:0] pb, frame_status_t st);
    frame_result_t r;
    r.kind           = k;
    r.payload_byte   = pb;
    r.packet_type    = ptype;
    r.type_class     = class_for(ptype);
    r.frame_status   = st;
    r.payload_length = len_byte;
    return r;
  endfunction

  task automatic expect_result(input frame_result_t r);
    frame_results_q = {frame_results_q, r};
  endtask

  function automatic int field_diff(string name, logic [15:0] e, logic [15:0] a);
    if (a !== e) begin
      $error("%s mismatch: expected %0h, actual %0h", name, e, a);
      return 1;
    end
    return 0;
  endfunction

  task automatic parse_rx_byte(input logic [7:0] b);
    int payload_end;
    payload_end = 4 + len_byte;
    if (!framing) begin
      if (sync_armed && b == sync_val) begin
        framing    = 1'b1;
        sync_armed = 1'b0;
        byte_pos   = 9'd1;
        len_byte   = 8'h00;
        crc_run    = CRC_INIT;
        ptype      = 16'h0000;
        crc_hi     = 8'h00;
      end else begin
        sync_armed = (b == sync_val);
      end
    end else begin
      byte_pos = byte_pos + 9'd1;
      if (byte_pos > index_limit) begin
        framing    = 1'b0;
        sync_armed = 1'b0;
        expect_result(make_result(KIND_END, 8'h00, STATUS_OVERSIZE));
      end else if (byte_pos == 9'd2 || byte_pos == 9'd3) begin
        ptype   = {ptype[7:0], b};
        crc_run = crc16_next(crc_run, b);
      end else if (byte_pos == 9'd4) begin
        len_byte = b;
        crc_run  = crc16_next(crc_run, b);
      end else if (int'(byte_pos) <= payload_end) begin
        crc_run = crc16_next(crc_run, b);
        expect_result(make_result(KIND_PAYLOAD, b, STATUS_CRC_GOOD));
      end else if (int'(byte_pos) == payload_end + 1) begin
        crc_hi = b;
      end else begin
        framing    = 1'b0;
        sync_armed = 1'b0;
        expect_result(make_result(KIND_END, 8'h00,
          ({crc_hi, b} == crc_run) ? STATUS_CRC_GOOD : STATUS_CRC_BAD));
      end
    end
  endtask

  initial begin
    fails    = 0;
    checked  = 0;
    good_cnt = 0;
    bad_cnt  = 0;
    drop_cnt = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      sync_val    = SYNC_BYTE_RST;
      index_limit = MAX_FRAME_INDEX_RST;
      framing     = 1'b0;
      sync_armed  = 1'b0;
      byte_pos    = 9'd0;
      len_byte    = 8'h00;
      crc_run     = CRC_INIT;
      ptype       = 16'h0000;
      crc_hi      = 8'h00;
      frame_results_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SYNC_BYTE:       sync_val    = cfg_wdata[7:0];
          CFG_MAX_FRAME_INDEX: index_limit = cfg_wdata[8:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        parse_rx_byte(in_rx_byte);
      end
      if (out_valid && !out_stall) begin
        if (frame_results_q.size() == 0) begin
          $error("result item with nothing expected");
          fails++;
        end else begin
          oldest = frame_results_q.pop_front();
          diffs  = 0;
          diffs += field_diff("kind", 16'(oldest.kind), 16'(out_kind));
          diffs += field_diff("payload_byte", 16'(oldest.payload_byte),
                              16'(out_payload_byte));
          diffs += field_diff("packet_type", oldest.packet_type, out_packet_type);
          diffs += field_diff("type_class", 16'(oldest.type_class),
                              16'(out_type_class));
          diffs += field_diff("frame_status", 16'(oldest.frame_status),
                              16'(out_frame_status));
          diffs += field_diff("payload_length", 16'(oldest.payload_length),
                              16'(out_payload_length));
          if (diffs != 0) fails++;
          checked++;
          if (oldest.kind == KIND_END) begin
            case (oldest.frame_status)
              STATUS_CRC_GOOD: good_cnt++;
              STATUS_CRC_BAD:  bad_cnt++;
              default:         drop_cnt++;
            endcase
          end
        end
      end
    end
    n_pending <= frame_results_q.size();
    n_fail    <= fails;
    n_checked <= checked;
    n_good    <= good_cnt;
    n_bad     <= bad_cnt;
    n_drop    <= drop_cnt;
  end

endmodule

FILE: tb/tb_sync_length_crc_frame_deframer.sv
// ----------------------------------------------------------------------------
// Frame deframer testbench
// Sends directed and random frames, noise and broken headers under several
// sync byte and frame limit settings, with random gaps and output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sync_length_crc_frame_deframer;
  import sldf_pkg::*;

  localparam logic [1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [1:0] CFG_SPARE_HI = 2'd3;
  localparam int         NUM_PHASES   = 8;
  localparam int         PHASE_BYTES  = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_kind;
  logic [7:0]  out_payload_byte;
  logic [15:0] out_packet_type;
  logic [1:0]  out_type_class;
  logic [1:0]  out_frame_status;
  logic [7:0]  out_payload_length;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_wdata = 16'h0000;

  int n_fail, n_pending, n_checked, n_good, n_bad, n_drop;

  bit         idle_on = 1'b0;
  bit         stall_on = 1'b0;
  int         bytes_sent = 0;
  int         n_settings = 0;
  logic [7:0] cur_sync = SYNC_BYTE_RST;

  sync_length_crc_frame_deframer u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .out_payload_byte(out_payload_byte), .out_packet_type(out_packet_type),
    .out_type_class(out_type_class), .out_frame_status(out_frame_status),
    .out_payload_length(out_payload_length),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  sync_length_crc_frame_deframer_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .out_payload_byte(out_payload_byte), .out_packet_type(out_packet_type),
    .out_type_class(out_type_class), .out_frame_status(out_frame_status),
    .out_payload_length(out_payload_length),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .n_fail(n_fail), .n_pending(n_pending), .n_checked(n_checked),
    .n_good(n_good), .n_bad(n_bad), .n_drop(n_drop)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("FAIL sync_length_crc_frame_deframer");
    $finish;
  end

  // output stall bursts
  initial begin
    forever begin
      @(posedge clk);
      if (stall_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    int          k;
    c = crc ^ {b, 8'h00};
    for (k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [15:0] ptype, input logic [7:0] len,
                            input bit corrupt);
    logic [7:0]  fr[$];
    logic [15:0] crc;
    logic [7:0]  b;
    int          i;
    crc = CRC_INIT;
    fr = {fr, cur_sync};
    fr = {fr, cur_sync};
    fr = {fr, ptype[15:8]};
    fr = {fr, ptype[7:0]};
    fr = {fr, len};
    for (i = 2; i < 5; i++) crc = crc_step(crc, fr[i]);
    for (i = 0; i < len; i++) begin
      b = 8'($urandom);
      fr = {fr, b};
      crc = crc_step(crc, b);
    end
    if (corrupt) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    fr = {fr, crc[15:8]};
    fr = {fr, crc[7:0]};
    foreach (fr[j]) send_byte(fr[j]);
  endtask

  task automatic wait_drained;
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == CFG_SYNC_BYTE) cur_sync = data[7:0];
    n_settings++;
  endtask

  task automatic random_chunk;
    int          pick;
    logic [15:0] ptype;
    logic [7:0]  len;
    int          i;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
      case ($urandom_range(0, 3))
        0:       ptype = TYPE_S1;
        1:       ptype = TYPE_G1;
        2:       ptype = TYPE_I1;
        default: ptype = 16'($urandom);
      endcase
      len = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(16, 80))
                                         : 8'($urandom_range(0, 10));
      send_frame(ptype, len, $urandom_range(0, 6) == 0);
    end else if (pick == 7) begin
      repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
    end else begin
      // header cut short; what follows is parsed as the rest of the frame
      send_byte(cur_sync);
      send_byte(cur_sync);
      for (i = $urandom_range(0, 4); i > 0; i--) send_byte(8'($urandom));
    end
  endtask

  initial begin
    logic [7:0] syncs [NUM_PHASES];
    logic [8:0] limits[NUM_PHASES];
    int         p;
    int         target;

    syncs  = '{8'h00, 8'hFF, 8'h55, 8'h00, 8'h7E, 8'h00, 8'h31, 8'h55};
    limits = '{9'd7, 9'd262, 9'd0, 9'd40, 9'd511, 9'd0, 9'd3, 9'd256};
    syncs[3]  = 8'($urandom);
    syncs[5]  = 8'($urandom);
    limits[5] = 9'($urandom_range(7, 262));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset register values, then a frame limit of 7
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(cur_sync);
    send_byte(8'h00);
    send_frame(TYPE_S1, 8'd1, 1'b0);
    send_frame(TYPE_G1, 8'd0, 1'b1);
    send_frame({cur_sync, 8'h31}, 8'd0, 1'b0);
    wait_drained;
    write_reg(CFG_MAX_FRAME_INDEX, {7'($urandom), 9'd7});
    send_frame(TYPE_I1, 8'd2, 1'b0);

    for (p = 0; p < NUM_PHASES; p++) begin
      wait_drained;
      write_reg(CFG_SYNC_BYTE, {8'($urandom), syncs[p]});
      write_reg(CFG_MAX_FRAME_INDEX, {7'($urandom), limits[p]});
      if (p == 3) begin
        write_reg(CFG_SPARE_LO, 16'($urandom));
        write_reg(CFG_SPARE_HI, 16'($urandom));
      end
      idle_on  = (p != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      stall_on = (p != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      if (p == 1) send_frame(TYPE_S1, 8'd255, 1'b0);
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) random_chunk();
    end

    wait_drained;
    $display("Covered %0d rx bytes over %0d register writes; %0d result items checked",
             bytes_sent, n_settings, n_checked);
    $display("End reports: %0d crc good, %0d crc bad, %0d oversize drops",
             n_good, n_bad, n_drop);
    if (n_fail == 0 && n_pending == 0) begin
      $display("PASS sync_length_crc_frame_deframer");
    end else begin
      $display("FAIL sync_length_crc_frame_deframer");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/sldf_pkg.sv
hw/rtl/sldf_crc16_byte.sv
hw/rtl/sync_length_crc_frame_deframer.sv
tb/sync_length_crc_frame_deframer_checker.sv
tb/tb_sync_length_crc_frame_deframer.sv
